/* sv/i2cmbs_pkg.sv */
// Shared types and codes for the I2C master bit sequencer.
// Used by the front decoder, the sequencer, the result queue and the top level.
package i2cmbs_pkg;

  localparam int DELAY_W   = 16;
  localparam int BYTE_W    = 8;
  localparam int BITCNT_W  = 4;
  localparam int ACTION_W  = 3;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd250;

  // action codes as they arrive on the input channel
  localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_ACK   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_READ  = 3'd5;

  // command class after decode; unused action codes become a plain tick
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_ACK,
    CMD_READ
  } cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   data_byte;
    logic                send_ack;
    logic                sda_sample;
  } in_item_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_data;
    logic              nack_seen;
    logic              rejected;
  } out_item_t;

  // decoded word held in the queue between front and sequencer
  typedef struct packed {
    cmd_t              cmd;
    logic [BYTE_W-1:0] data_byte;
    logic              send_ack;
    logic              sda_sample;
  } q_item_t;

endpackage

/* sv/i2c_master_bit_sequencer_core.sv */
// I2C master bit sequencer: generates SCL/SDA pin sequences for start, stop,
// write byte, ACK sampling and read byte, one word per system tick.
// Input channel: push/full with req (action, data_byte, send_ack, sda_sample);
//   a word is taken when push is high and full is low. Action 0 and the unused
//   codes are plain ticks; a command while a sequence runs is flagged rejected.
// Result channel: empty/pop with rsp; one result word per input word, in order.
// Configuration: cfg_valid/cfg_ready/cfg_data writes delay_ticks (reset 250);
//   cfg_ready is always high. Write it only while the block is idle.
// Path: a pushed word is registered in the decode queue, then goes through the
//   sequencer into the result queue, where it shows as empty low.
// Throughput: one word per cycle while the result queue is not full, set by the sequencer step.
// A stalled receiver fills the two-entry result queue, which halts the
// sequencer, then fills the two-entry input queue, which raises full.
// Reset (rst, synchronous) empties both queues, sets SCL and SDA high and
// driven, phase idle and delay_ticks to 250.
// Depends on i2cmbs_pkg, i2cmbs_front, i2cmbs_seq, i2cmbs_outq.
module i2c_master_bit_sequencer_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  i2cmbs_pkg::in_item_t  req,
  output logic                  empty,
  input  logic                  pop,
  output i2cmbs_pkg::out_item_t rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_data
);
  import i2cmbs_pkg::*;

  logic      q_valid;
  logic      q_take;
  q_item_t   q_item;
  logic      res_full;
  logic      res_wr;
  out_item_t res;

  i2cmbs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .req     (req),
    .q_valid (q_valid),
    .q_take  (q_take),
    .q_item  (q_item)
  );

  i2cmbs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .q_item    (q_item),
    .res_full  (res_full),
    .res_wr    (res_wr),
    .res       (res)
  );

  i2cmbs_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .wr       (res_wr),
    .wr_item  (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .rsp      (rsp)
  );

`ifndef NO_ASSERTIONS
  // a finished sequence never reports itself still busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res_wr && res.done_res |-> !res.busy_res)
    else $error("done and busy reported together");

  // an accepted word is waiting for the sequencer on the next cycle
  a_push_queued: assert property (@(posedge clk) disable iff (rst)
    push && !full |=> q_valid)
    else $error("accepted word lost in front queue");

  // a rejected command only occurs while a sequence keeps running or just ended
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    res_wr && res.rejected |-> res.busy_res || res.done_res || q_item.cmd != CMD_NONE)
    else $error("rejection outside a running sequence");

  // reset empties both queues
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty && !q_valid)
    else $error("queues not empty after reset");
`endif

endmodule

/* sv/i2cmbs_front.sv */
// Front end of the I2C master bit sequencer: decodes incoming words and holds
// them in a two-entry queue for the sequencer. Depends on i2cmbs_pkg.
module i2cmbs_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  i2cmbs_pkg::in_item_t req,
  output logic                 q_valid,
  input  logic                 q_take,
  output i2cmbs_pkg::q_item_t  q_item
);
  import i2cmbs_pkg::*;

  q_item_t    slot [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push_ok;
  logic       pop_ok;
  q_item_t    dec;

  always_comb begin
    case (req.action)
      ACT_START: dec.cmd = CMD_START;
      ACT_STOP:  dec.cmd = CMD_STOP;
      ACT_WRITE: dec.cmd = CMD_WRITE;
      ACT_ACK:   dec.cmd = CMD_ACK;
      ACT_READ:  dec.cmd = CMD_READ;
      default:   dec.cmd = CMD_NONE;
    endcase
    dec.data_byte  = req.data_byte;
    dec.send_ack   = req.send_ack;
    dec.sda_sample = req.sda_sample;
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slot[rd_ptr];
  assign push_ok = push & ~full;
  assign pop_ok  = q_take & q_valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push_ok, pop_ok})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/i2cmbs_seq.sv */
// Back end of the I2C master bit sequencer: runs the start, stop, write, ack and
// read pin sequences, one queued word per cycle unless the result queue is full. Depends on i2cmbs_pkg.
module i2cmbs_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [15:0]            cfg_data,
  input  logic                   q_valid,
  output logic                   q_take,
  input  i2cmbs_pkg::q_item_t    q_item,
  input  logic                   res_full,
  output logic                   res_wr,
  output i2cmbs_pkg::out_item_t  res
);
  import i2cmbs_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_A,
    PH_ST_B,
    PH_SP_A,
    PH_SP_B,
    PH_WR_HI,
    PH_WR_LO,
    PH_AK_A,
    PH_AK_B,
    PH_RD_HI,
    PH_RD_LO,
    PH_RD_ACK
  } phase_t;

  logic [DELAY_W-1:0]  delay_ticks;
  phase_t              phase, phase_next;
  logic [BITCNT_W-1:0] bit_count, bit_count_next;
  logic [BYTE_W-1:0]   shift_reg, shift_reg_next;
  logic [DELAY_W-1:0]  wait_count, wait_count_next;
  logic                scl, scl_next;
  logic                sda, sda_next;
  logic                sda_oe, sda_oe_next;
  logic                ack_choice, ack_choice_next;
  logic                nack, nack_next;
  logic                done;
  logic                rej;
  logic [DELAY_W-1:0]  arm_val;
  logic [BITCNT_W-1:0] bc_inc;
  logic [BYTE_W-1:0]   wr_shift;

  assign cfg_ready = 1'b1;
  assign q_take    = q_valid & ~res_full;
  assign res_wr    = q_take;

  // a zero delay counts as one tick
  assign arm_val  = (delay_ticks == '0) ? {{(DELAY_W-1){1'b0}}, 1'b1} : delay_ticks;
  assign bc_inc   = bit_count + {{(BITCNT_W-1){1'b0}}, 1'b1};
  assign wr_shift = shift_reg << bc_inc[2:0];

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    wait_count_next = wait_count;
    scl_next        = scl;
    sda_next        = sda;
    sda_oe_next     = sda_oe;
    ack_choice_next = ack_choice;
    nack_next       = nack;
    done            = 1'b0;
    rej             = 1'b0;
    if (phase != PH_IDLE) begin
      rej = (q_item.cmd != CMD_NONE);
      if (wait_count > {{(DELAY_W-1){1'b0}}, 1'b1}) begin
        wait_count_next = wait_count - {{(DELAY_W-1){1'b0}}, 1'b1};
      end else begin
        wait_count_next = '0;
        case (phase)
          PH_ST_A: begin
            sda_next = 1'b0; phase_next = PH_ST_B; wait_count_next = arm_val;
          end
          PH_ST_B: begin
            scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
          end
          PH_SP_A: begin
            sda_next = 1'b1; phase_next = PH_SP_B; wait_count_next = arm_val;
          end
          PH_SP_B: begin
            phase_next = PH_IDLE; done = 1'b1;
          end
          PH_WR_HI: begin
            scl_next = 1'b0; phase_next = PH_WR_LO; wait_count_next = arm_val;
          end
          PH_WR_LO: begin
            bit_count_next = bc_inc;
            if (bc_inc[BITCNT_W-1]) begin
              phase_next = PH_IDLE; done = 1'b1;
            end else begin
              sda_next = wr_shift[BYTE_W-1]; scl_next = 1'b1;
              phase_next = PH_WR_HI; wait_count_next = arm_val;
            end
          end
          PH_AK_A: begin
            scl_next = 1'b1; phase_next = PH_AK_B; wait_count_next = arm_val;
          end
          PH_AK_B: begin
            nack_next = q_item.sda_sample;
            scl_next = 1'b0; sda_oe_next = 1'b1; sda_next = 1'b1;
            phase_next = PH_IDLE; done = 1'b1;
          end
          PH_RD_HI: begin
            shift_reg_next = {shift_reg[BYTE_W-2:0], q_item.sda_sample};
            scl_next = 1'b0; phase_next = PH_RD_LO; wait_count_next = arm_val;
          end
          PH_RD_LO: begin
            bit_count_next = bc_inc;
            scl_next = 1'b1; wait_count_next = arm_val;
            if (bc_inc[BITCNT_W-1]) begin
              // byte complete: drive the answer bit
              sda_oe_next = 1'b1; sda_next = ~ack_choice; phase_next = PH_RD_ACK;
            end else begin
              phase_next = PH_RD_HI;
            end
          end
          PH_RD_ACK: begin
            scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end else begin
      case (q_item.cmd)
        CMD_START: begin
          sda_oe_next = 1'b1; sda_next = 1'b1; scl_next = 1'b1;
          phase_next = PH_ST_A; wait_count_next = arm_val;
        end
        CMD_STOP: begin
          sda_oe_next = 1'b1; sda_next = 1'b0; scl_next = 1'b1;
          phase_next = PH_SP_A; wait_count_next = arm_val;
        end
        CMD_WRITE: begin
          shift_reg_next = q_item.data_byte; bit_count_next = '0; sda_oe_next = 1'b1;
          sda_next = q_item.data_byte[BYTE_W-1]; scl_next = 1'b1;
          phase_next = PH_WR_HI; wait_count_next = arm_val;
        end
        CMD_ACK: begin
          sda_oe_next = 1'b0; phase_next = PH_AK_A; wait_count_next = arm_val;
        end
        CMD_READ: begin
          ack_choice_next = q_item.send_ack; shift_reg_next = '0; bit_count_next = '0;
          sda_oe_next = 1'b0; scl_next = 1'b1;
          phase_next = PH_RD_HI; wait_count_next = arm_val;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.scl_level = scl_next;
    res.sda_level = sda_next;
    res.sda_drive = sda_oe_next;
    res.busy_res  = (phase_next != PH_IDLE);
    res.done_res  = done;
    res.read_data = shift_reg_next;
    res.nack_seen = nack_next;
    res.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= DELAY_RESET;
      phase       <= PH_IDLE;
      bit_count   <= '0;
      shift_reg   <= '0;
      wait_count  <= '0;
      scl         <= 1'b1;
      sda         <= 1'b1;
      sda_oe      <= 1'b1;
      ack_choice  <= 1'b0;
      nack        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        delay_ticks <= cfg_data;
      end
      if (q_take) begin
        phase      <= phase_next;
        bit_count  <= bit_count_next;
        shift_reg  <= shift_reg_next;
        wait_count <= wait_count_next;
        scl        <= scl_next;
        sda        <= sda_next;
        sda_oe     <= sda_oe_next;
        ack_choice <= ack_choice_next;
        nack       <= nack_next;
      end
    end
  end

endmodule

/* sv/i2cmbs_outq.sv */
// Result queue of the I2C master bit sequencer: two-entry buffer between the
// sequencer and the receiver. Depends on i2cmbs_pkg.
module i2cmbs_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  i2cmbs_pkg::out_item_t wr_item,
  output logic                  res_full,
  output logic                  empty,
  input  logic                  pop,
  output i2cmbs_pkg::out_item_t rsp
);
  import i2cmbs_pkg::*;

  out_item_t  slot [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       pop_ok;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign rsp      = slot[rd_ptr];
  assign pop_ok   = pop & ~empty;

  always_ff @(posedge clk) begin
    if (wr) begin
      slot[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr, pop_ok})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* tb/i2c_master_bit_sequencer_core_test.sv */
// Self-checking testbench for i2c_master_bit_sequencer_core: sends commands and ticks
// on the push/full port, predicts each pin word and checks it on the empty/pop port.
// Depends on i2cmbs_pkg and the core RTL only.
`timescale 1ns / 100ps

module i2c_master_bit_sequencer_core_test;
  import i2cmbs_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 40;
  localparam int STALL_LIMIT   = 2000;
  localparam int REPORT_CAP    = 200;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_START_HI,
    SEQ_START_LO,
    SEQ_STOP_LO,
    SEQ_STOP_HI,
    SEQ_WR_HI,
    SEQ_WR_LO,
    SEQ_ACK_REL,
    SEQ_ACK_HI,
    SEQ_RD_HI,
    SEQ_RD_LO,
    SEQ_RD_ACK
  } seq_phase_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  in_item_t    req;
  logic        empty;
  logic        pop;
  out_item_t   rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // predicted bus state
  seq_phase_t        bus_phase;
  logic [3:0]        bits_done;
  logic [BYTE_W-1:0] shifter;
  logic [15:0]       delay_left;
  logic              scl_q;
  logic              sda_q;
  logic              sda_oe_q;
  logic              ack_answer;
  logic              nack_q;
  logic [15:0]       delay_cfg;

  out_item_t pins_due[$];
  int        words_sent;
  int        mismatches;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        sda_one_pct;
  int        noise_pct;
  bit        hold_start;

  i2c_master_bit_sequencer_core dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .empty     (empty),
    .pop       (pop),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic reset_bus_model();
    bus_phase  = SEQ_IDLE;
    bits_done  = '0;
    shifter    = '0;
    delay_left = '0;
    scl_q      = 1'b1;
    sda_q      = 1'b1;
    sda_oe_q   = 1'b1;
    ack_answer = 1'b0;
    nack_q     = 1'b0;
    delay_cfg  = DELAY_RESET;
  endtask

  // a zero delay behaves as one tick
  function automatic void arm_delay(seq_phase_t next);
    bus_phase  = next;
    delay_left = (delay_cfg == '0) ? 16'd1 : delay_cfg;
  endfunction

  function automatic out_item_t predict_bus_word(in_item_t w);
    out_item_t r;
    logic      finished;
    logic      refused;
    finished = 1'b0;
    refused  = 1'b0;
    if (bus_phase != SEQ_IDLE) begin
      refused = (w.action >= ACT_START) && (w.action <= ACT_READ);
      if (delay_left > 16'd1) begin
        delay_left = delay_left - 16'd1;
      end else begin
        delay_left = '0;
        case (bus_phase)
          SEQ_START_HI: begin
            sda_q = 1'b0;
            arm_delay(SEQ_START_LO);
          end
          SEQ_START_LO: begin
            scl_q = 1'b0;
            bus_phase = SEQ_IDLE;
            finished = 1'b1;
          end
          SEQ_STOP_LO: begin
            sda_q = 1'b1;
            arm_delay(SEQ_STOP_HI);
          end
          SEQ_STOP_HI: begin
            bus_phase = SEQ_IDLE;
            finished = 1'b1;
          end
          SEQ_WR_HI: begin
            scl_q = 1'b0;
            arm_delay(SEQ_WR_LO);
          end
          SEQ_WR_LO: begin
            bits_done = bits_done + 4'd1;
            if (bits_done >= 4'(BYTE_W)) begin
              bus_phase = SEQ_IDLE;
              finished = 1'b1;
            end else begin
              sda_q = shifter[3'd7 - bits_done[2:0]];
              scl_q = 1'b1;
              arm_delay(SEQ_WR_HI);
            end
          end
          SEQ_ACK_REL: begin
            scl_q = 1'b1;
            arm_delay(SEQ_ACK_HI);
          end
          SEQ_ACK_HI: begin
            nack_q = w.sda_sample;
            scl_q = 1'b0;
            sda_oe_q = 1'b1;
            sda_q = 1'b1;
            bus_phase = SEQ_IDLE;
            finished = 1'b1;
          end
          SEQ_RD_HI: begin
            shifter = {shifter[BYTE_W-2:0], w.sda_sample};
            scl_q = 1'b0;
            arm_delay(SEQ_RD_LO);
          end
          SEQ_RD_LO: begin
            bits_done = bits_done + 4'd1;
            scl_q = 1'b1;
            if (bits_done >= 4'(BYTE_W)) begin
              sda_oe_q = 1'b1;
              sda_q = ~ack_answer;
              arm_delay(SEQ_RD_ACK);
            end else begin
              arm_delay(SEQ_RD_HI);
            end
          end
          SEQ_RD_ACK: begin
            scl_q = 1'b0;
            bus_phase = SEQ_IDLE;
            finished = 1'b1;
          end
          default: bus_phase = SEQ_IDLE;
        endcase
      end
    end else begin
      case (w.action)
        ACT_START: begin
          sda_oe_q = 1'b1;
          sda_q = 1'b1;
          scl_q = 1'b1;
          arm_delay(SEQ_START_HI);
        end
        ACT_STOP: begin
          sda_oe_q = 1'b1;
          sda_q = 1'b0;
          scl_q = 1'b1;
          arm_delay(SEQ_STOP_LO);
        end
        ACT_WRITE: begin
          shifter = w.data_byte;
          bits_done = '0;
          sda_oe_q = 1'b1;
          sda_q = w.data_byte[BYTE_W-1];
          scl_q = 1'b1;
          arm_delay(SEQ_WR_HI);
        end
        ACT_ACK: begin
          sda_oe_q = 1'b0;
          arm_delay(SEQ_ACK_REL);
        end
        ACT_READ: begin
          ack_answer = w.send_ack;
          shifter = '0;
          bits_done = '0;
          sda_oe_q = 1'b0;
          scl_q = 1'b1;
          arm_delay(SEQ_RD_HI);
        end
        default: ;
      endcase
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.sda_drive = sda_oe_q;
    r.busy_res  = (bus_phase != SEQ_IDLE);
    r.done_res  = finished;
    r.read_data = shifter;
    r.nack_seen = nack_q;
    r.rejected  = refused;
    return r;
  endfunction

  // hold push across back-to-back words; drop it only for a gap
  task automatic send_word(in_item_t w);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push = 1'b1;
    req  = w;
    do @(posedge clk); while (full);
    pins_due.push_back(predict_bus_word(w));
    words_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    push = 1'b0;
    while (pins_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_delay(logic [15:0] ticks);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = ticks;
    do @(posedge clk); while (!cfg_ready);
    delay_cfg = ticks;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic in_item_t make_tick();
    in_item_t w;
    w.action = ACT_TICK;
    if ($urandom_range(99) < noise_pct) w.action = 3'($urandom_range(7));
    w.data_byte  = 8'($urandom_range(255));
    w.send_ack   = 1'($urandom_range(1));
    w.sda_sample = ($urandom_range(99) < sda_one_pct);
    return w;
  endfunction

  // issue one command, then tick until the sequence ends
  task automatic run_command(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] data, logic ack);
    in_item_t w;
    w.action     = act;
    w.data_byte  = data;
    w.send_ack   = ack;
    w.sda_sample = 1'($urandom_range(1));
    send_word(w);
    while (bus_phase != SEQ_IDLE) send_word(make_tick());
  endtask

  task automatic random_transaction();
    int n;
    if ($urandom_range(99) < 15)
      write_delay(16'(($urandom_range(99) < 80) ? $urandom_range(4) : $urandom_range(12, 5)));
    run_command(ACT_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
    n = $urandom_range(3, 1);
    repeat (n) begin
      if ($urandom_range(1)) begin
        run_command(ACT_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)));
        run_command(ACT_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        run_command(ACT_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      if ($urandom_range(99) < 5) drain_results();
    end
    run_command(ACT_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)));
    // loose words and broken sequences
    if ($urandom_range(99) < 10)
      repeat ($urandom_range(4, 1))
        run_command(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic test_reset_values();
    in_item_t w;
    w = '0;
    send_word(w);
    w.action = 3'd6;
    w.sda_sample = 1'b1;
    send_word(w);
    w.action = 3'd7;
    w.data_byte = 8'hFF;
    w.send_ack = 1'b1;
    send_word(w);
    // stop at the reset delay
    run_command(ACT_STOP, 8'h00, 1'b0);
  endtask

  task automatic test_commands();
    write_delay(16'd1);
    run_command(ACT_START, 8'h00, 1'b0);
    run_command(ACT_WRITE, 8'hFF, 1'b0);
    sda_one_pct = 0;
    run_command(ACT_ACK, 8'h00, 1'b0);
    run_command(ACT_WRITE, 8'h00, 1'b1);
    sda_one_pct = 100;
    run_command(ACT_ACK, 8'h00, 1'b0);
    run_command(ACT_READ, 8'h00, 1'b1);
    sda_one_pct = 0;
    run_command(ACT_READ, 8'hFF, 1'b0);
    sda_one_pct = 50;
    run_command(ACT_WRITE, 8'hA5, 1'b0);
    run_command(ACT_STOP, 8'h00, 1'b0);
    // commands and spare codes while a sequence runs
    noise_pct = 60;
    run_command(ACT_WRITE, 8'h5A, 1'b1);
    noise_pct = 0;
  endtask

  task automatic test_delay_extremes();
    in_item_t w;
    write_delay(16'd0);
    run_command(ACT_START, 8'h00, 1'b0);
    run_command(ACT_WRITE, 8'hC3, 1'b0);
    run_command(ACT_ACK, 8'h00, 1'b0);
    run_command(ACT_STOP, 8'h00, 1'b0);
    write_delay(16'd2);
    run_command(ACT_READ, 8'h00, 1'b1);
    write_delay(16'd40);
    w = '0;
    w.action = ACT_START;
    send_word(w);
    w.action = ACT_READ;
    send_word(w);
    w.action = 3'd7;
    send_word(w);
    while (bus_phase != SEQ_IDLE) send_word(make_tick());
    write_delay(16'd1);
  endtask

  // stall the receiver while words keep coming so the input queue fills
  task automatic test_receiver_hold();
    write_delay(16'd1);
    hold_start = 1'b1;
    run_command(ACT_START, 8'h00, 1'b0);
    run_command(ACT_WRITE, 8'($urandom_range(255)), 1'b0);
    run_command(ACT_ACK, 8'h00, 1'b0);
    run_command(ACT_STOP, 8'h00, 1'b0);
    drain_results();
  endtask

  // pause the sender mid-sequence until every result is back
  task automatic test_sender_pause();
    write_delay(16'd3);
    send_word(in_item_t'{action: ACT_WRITE, data_byte: 8'h96, send_ack: 1'b0, sda_sample: 1'b0});
    repeat (5) send_word(make_tick());
    drain_results();
    while (bus_phase != SEQ_IDLE) send_word(make_tick());
  endtask

  task automatic test_random(int send_pct, int recv_pct, int goal);
    int first;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    noise_pct = 5;
    first = words_sent;
    while (words_sent - first < goal) random_transaction();
    noise_pct = 0;
  endtask

  task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      // keep the log short on a badly broken build
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (pins_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, actual %h", $time, rsp);
      end else begin
        want = pins_due.pop_front();
        check_field("scl_level", 8'(want.scl_level), 8'(rsp.scl_level));
        check_field("sda_level", 8'(want.sda_level), 8'(rsp.sda_level));
        check_field("sda_drive", 8'(want.sda_drive), 8'(rsp.sda_drive));
        check_field("busy_res", 8'(want.busy_res), 8'(rsp.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(rsp.done_res));
        check_field("read_data", want.read_data, rsp.read_data);
        check_field("nack_seen", 8'(want.nack_seen), 8'(rsp.nack_seen));
        check_field("rejected", 8'(want.rejected), 8'(rsp.rejected));
      end
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_left = HOLD_CYCLES;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else begin
        pop = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    hold_start = 1'b0;
    words_sent = 0;
    mismatches = 0;
    send_idle_pct = 9;
    recv_idle_pct = 68;
    sda_one_pct = 50;
    noise_pct = 0;
    reset_bus_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_commands();
    test_random(9, 68, 270);
    test_random(68, 9, 270);
    test_random(0, 0, 270);
    test_receiver_hold();
    test_sender_pause();
    test_delay_extremes();

    drain_results();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
